@@ sv/e2r_pkg.sv @@
// ----------------------------------------------------------------------------
// e2r_pkg: shared types and constants for the Euler-angle to rotation-matrix block
// Payload structs, CORDIC arctangent table and fixed-point helpers.
// ----------------------------------------------------------------------------
package e2r_pkg;

	localparam int ANGLE_BITS    = 16;
	localparam int FRAC_BITS     = 14;
	localparam int CORDIC_STAGES = 16;
	localparam int NSTG          = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
	localparam int INT_FRAC      = 30;
	localparam int OUT_BITS      = 16;
	// Q2.30 datapath needs guard bits for the gain growth
	localparam int CW            = 34;
	localparam int VW            = FRAC_BITS + 2;      // clamped value width
	localparam int PW            = 2 * VW;             // product width
	localparam int SW            = PW + 1;             // sum width

	localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);
	localparam logic signed [VW-1:0] ONE_V       = VW'(1 << FRAC_BITS);

	typedef struct packed {
		logic signed [15:0] roll_angle;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] yaw_angle;
	} req_t;

	typedef struct packed {
		logic signed [15:0] m00;
		logic signed [15:0] m01;
		logic signed [15:0] m02;
		logic signed [15:0] m10;
		logic signed [15:0] m11;
		logic signed [15:0] m12;
		logic signed [15:0] m20;
		logic signed [15:0] m21;
		logic signed [15:0] m22;
	} rsp_t;

	typedef struct packed {
		logic signed [VW-1:0] c;
		logic signed [VW-1:0] s;
	} sc_t;

	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] t [32];
		t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
			32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
			32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
			32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
			32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
			32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
			32'h00000001, 32'h00000000};
		return t[i];
	endfunction

	// round half up from Q30 to FRAC_BITS, then clamp to +-1
	function automatic logic signed [VW-1:0] scale_q30(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] r;
		r = (v + (CW'(1) <<< (INT_FRAC - FRAC_BITS - 1))) >>> (INT_FRAC - FRAC_BITS);
		if (r > CW'(ONE_V)) return ONE_V;
		if (r < -CW'(ONE_V)) return -ONE_V;
		return r[VW-1:0];
	endfunction

	// round half up from 2*FRAC_BITS to FRAC_BITS, then clamp to +-1
	function automatic logic signed [VW-1:0] finish(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] r;
		r = (v + (SW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		if (r > SW'(ONE_V)) return ONE_V;
		if (r < -SW'(ONE_V)) return -ONE_V;
		return r[VW-1:0];
	endfunction

endpackage

@@ sv/e2r_cordic.sv @@
// ----------------------------------------------------------------------------
// e2r_cordic: pipelined sine/cosine lane
// Quadrant fold, one CORDIC micro-rotation per stage, scaling and unfold.
// Advances when en is high.
// ----------------------------------------------------------------------------
module e2r_cordic (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [e2r_pkg::ANGLE_BITS-1:0] angle,
	output e2r_pkg::sc_t                         sc
);
	localparam int N  = e2r_pkg::NSTG;
	localparam int CW = e2r_pkg::CW;

	logic signed [CW-1:0] x_q [N+1];
	logic signed [CW-1:0] y_q [N+1];
	logic signed [CW-1:0] z_q [N+1];
	logic [1:0]           quad_q [N+1];
	logic [31:0]          turn;
	logic [31:0]          bias;
	logic [31:0]          resid;

	// fold into one quadrant
	assign turn  = {angle, {(32 - e2r_pkg::ANGLE_BITS){1'b0}}};
	assign bias  = turn + 32'h20000000;
	assign resid = turn - {bias[31:30], 30'd0};

	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0]    <= e2r_pkg::CORDIC_GAIN;
			y_q[0]    <= '0;
			z_q[0]    <= CW'(signed'(resid));
			quad_q[0] <= bias[31:30];
		end
	end

	// micro-rotation stages
	for (genvar i = 0; i < N; i++) begin : g_stg
		logic signed [CW-1:0] a;
		assign a = CW'(e2r_pkg::atan_turn(i));
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_q[i][CW-1]) begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - a;
				end else begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + a;
				end
				quad_q[i+1] <= quad_q[i];
			end
		end
	end

	// scale and unfold quadrant
	logic signed [e2r_pkg::VW-1:0] c, s;
	assign c = e2r_pkg::scale_q30(x_q[N]);
	assign s = e2r_pkg::scale_q30(y_q[N]);

	always_comb begin
		case (quad_q[N])
			2'd0:    begin sc.c = c;  sc.s = s;  end
			2'd1:    begin sc.c = -s; sc.s = c;  end
			2'd2:    begin sc.c = -c; sc.s = -s; end
			default: begin sc.c = s;  sc.s = -c; end
		endcase
	end
endmodule

@@ sv/e2r_merge.sv @@
// ----------------------------------------------------------------------------
// e2r_merge: matrix product stages
// Combines the three lanes' sine/cosine pairs into the nine entries.
// Three register stages, advancing when en is high.
// ----------------------------------------------------------------------------
module e2r_merge (
	input  logic         clk,
	input  logic         en,
	input  e2r_pkg::sc_t x,
	input  e2r_pkg::sc_t y,
	input  e2r_pkg::sc_t z,
	output e2r_pkg::rsp_t rsp
);
	localparam int VW = e2r_pkg::VW;
	localparam int PW = e2r_pkg::PW;
	localparam int SW = e2r_pkg::SW;

	e2r_pkg::sc_t x_s1, y_s1, z_s1;
	logic signed [VW-1:0] sxsy_s1, cxsy_s1;
	logic signed [PW-1:0] p_sxsy, p_cxsy;

	// stage 1: two-factor prefix for the three-factor terms
	assign p_sxsy = PW'(x.s) * PW'(y.s);
	assign p_cxsy = PW'(x.c) * PW'(y.s);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= x;
			y_s1    <= y;
			z_s1    <= z;
			sxsy_s1 <= e2r_pkg::finish(SW'(p_sxsy));
			cxsy_s1 <= e2r_pkg::finish(SW'(p_cxsy));
		end
	end

	// stage 2: products
	logic signed [PW-1:0] cycz_s2, cysz_s2, sxcy_s2, cxcy_s2;
	logic signed [PW-1:0] a01_s2, b01_s2, a02_s2, b02_s2;
	logic signed [PW-1:0] a11_s2, b11_s2, a12_s2, b12_s2;
	logic signed [VW-1:0] sy_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			cycz_s2 <= PW'(y_s1.c) * PW'(z_s1.c);
			cysz_s2 <= PW'(y_s1.c) * PW'(z_s1.s);
			sxcy_s2 <= PW'(x_s1.s) * PW'(y_s1.c);
			cxcy_s2 <= PW'(x_s1.c) * PW'(y_s1.c);
			a01_s2  <= PW'(sxsy_s1) * PW'(z_s1.c);
			b01_s2  <= PW'(x_s1.c) * PW'(z_s1.s);
			a02_s2  <= PW'(cxsy_s1) * PW'(z_s1.c);
			b02_s2  <= PW'(x_s1.s) * PW'(z_s1.s);
			a11_s2  <= PW'(sxsy_s1) * PW'(z_s1.s);
			b11_s2  <= PW'(x_s1.c) * PW'(z_s1.c);
			a12_s2  <= PW'(cxsy_s1) * PW'(z_s1.s);
			b12_s2  <= PW'(x_s1.s) * PW'(z_s1.c);
			sy_s2   <= y_s1.s;
		end
	end

	// stage 3: sums, rounding and clamping
	always_ff @(posedge clk) begin
		if (en) begin
			rsp.m00 <= 16'(e2r_pkg::finish(SW'(cycz_s2)));
			rsp.m01 <= 16'(e2r_pkg::finish(SW'(a01_s2) - SW'(b01_s2)));
			rsp.m02 <= 16'(e2r_pkg::finish(SW'(a02_s2) + SW'(b02_s2)));
			rsp.m10 <= 16'(e2r_pkg::finish(SW'(cysz_s2)));
			rsp.m11 <= 16'(e2r_pkg::finish(SW'(a11_s2) + SW'(b11_s2)));
			rsp.m12 <= 16'(e2r_pkg::finish(SW'(a12_s2) - SW'(b12_s2)));
			rsp.m20 <= 16'(-sy_s2);
			rsp.m21 <= 16'(e2r_pkg::finish(SW'(sxcy_s2)));
			rsp.m22 <= 16'(e2r_pkg::finish(SW'(cxcy_s2)));
		end
	end
endmodule

@@ sv/euler_to_rotation_matrix.sv @@
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix: Z-Y-X Euler angles to rotation matrix
// Three CORDIC lanes feeding a product/merge pipeline.
// ----------------------------------------------------------------------------
// Takes roll, pitch and yaw as 16-bit binary angles (32768 = pi) and returns
// R = Rz*Ry*Rx as nine signed Q1.14 entries saturated to +-16384. One request
// is accepted every cycle unless the output is held; the pipeline is one fold
// stage, one stage per CORDIC iteration and three product stages. The whole
// pipeline stalls together when the output is held, so throughput is set only
// by the downstream ready.
module euler_to_rotation_matrix (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  e2r_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output e2r_pkg::rsp_t out_data
);
	localparam int LAT = e2r_pkg::NSTG + 4;

	logic           en;
	logic [LAT-1:0] vld_q;
	e2r_pkg::sc_t   sc_x, sc_y, sc_z;

	// pipeline advances unless the last stage holds an untaken result
	assign en        = !vld_q[LAT-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	e2r_cordic u_lane_x (.clk(clk), .en(en), .angle(in_data.roll_angle),  .sc(sc_x));
	e2r_cordic u_lane_y (.clk(clk), .en(en), .angle(in_data.pitch_angle), .sc(sc_y));
	e2r_cordic u_lane_z (.clk(clk), .en(en), .angle(in_data.yaw_angle),   .sc(sc_z));

	e2r_merge u_merge (
		.clk(clk), .en(en), .x(sc_x), .y(sc_y), .z(sc_z), .rsp(out_data)
	);
endmodule

@@ test/tb_euler_to_rotation_matrix.sv @@
// ----------------------------------------------------------------------------
// tb_euler_to_rotation_matrix: self-checking bench for the Euler-to-matrix block
// Drives angle triples with random idling and a long output hold-off, predicts
// each matrix through a bit-exact CORDIC model and checks results in order.
// ----------------------------------------------------------------------------
module tb_euler_to_rotation_matrix;

	localparam int HALF_PERIOD = 5;
	localparam int WATCHDOG    = 20000;
	localparam int N_RANDOM    = 900;
	localparam int ONE         = 1 << 14;

	// Matrix predictor and store of expected matrices
	class matrix_scoreboard;
		e2r_pkg::rsp_t pending[$];
		int            errors;

		function longint fshift(longint v, int s);
			return v >>> s;
		endfunction

		function longint rnd(longint v, int s);
			return fshift(v + (longint'(1) << (s - 1)), s);
		endfunction

		function longint sat(longint v);
			if (v > ONE) return ONE;
			if (v < -ONE) return -ONE;
			return v;
		endfunction

		function void trig(logic [15:0] ang, output longint c, output longint s);
			logic [31:0] turn, ru;
			logic [1:0]  q;
			longint x, y, z, dx, dy, cc, ss;
			turn = {ang, 16'h0};
			q    = 2'((turn + 32'h20000000) >> 30);
			ru   = turn - (32'(q) << 30);
			z    = longint'(signed'(ru));
			x    = 652032874;
			y    = 0;
			for (int i = 0; i < e2r_pkg::NSTG; i++) begin
				dx = fshift(y, i);
				dy = fshift(x, i);
				if (z >= 0) begin
					x -= dx; y += dy; z -= longint'(e2r_pkg::atan_turn(i));
				end else begin
					x += dx; y -= dy; z += longint'(e2r_pkg::atan_turn(i));
				end
			end
			cc = sat(rnd(x, 16));
			ss = sat(rnd(y, 16));
			case (q)
				2'd0: begin c = cc; s = ss; end
				2'd1: begin c = -ss; s = cc; end
				2'd2: begin c = -cc; s = -ss; end
				default: begin c = ss; s = -cc; end
			endcase
		endfunction

		function logic [15:0] fin(longint v);
			return 16'(sat(rnd(v, 14)));
		endfunction

		// note an accepted request
		function void note_request(e2r_pkg::req_t r);
			longint cx, sx, cy, sy, cz, sz, sxsy, cxsy;
			e2r_pkg::rsp_t m;
			trig(r.roll_angle, cx, sx);
			trig(r.pitch_angle, cy, sy);
			trig(r.yaw_angle, cz, sz);
			sxsy  = sat(rnd(sx * sy, 14));
			cxsy  = sat(rnd(cx * sy, 14));
			m.m00 = fin(cy * cz);
			m.m01 = fin(sxsy * cz - cx * sz);
			m.m02 = fin(cxsy * cz + sx * sz);
			m.m10 = fin(cy * sz);
			m.m11 = fin(sxsy * sz + cx * cz);
			m.m12 = fin(cxsy * sz - sx * cz);
			m.m20 = 16'(-sy);
			m.m21 = fin(sx * cy);
			m.m22 = fin(cx * cy);
			pending = {pending, m};
		endfunction

		// compare a result against the oldest expected matrix
		function void check_result(e2r_pkg::rsp_t got);
			e2r_pkg::rsp_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			for (int k = 0; k < 9; k++)
				if (e[16*k +: 16] !== got[16*k +: 16]) begin
					$display("%0t: entry %0d expected %0d actual %0d", $time, 8 - k,
						$signed(e[16*k +: 16]), $signed(got[16*k +: 16]));
					errors++;
				end
		endfunction
	endclass

	logic          clk = 0;
	logic          arst_n = 0;
	logic          in_valid = 0;
	logic          in_ready;
	e2r_pkg::req_t in_data = '0;
	logic          out_valid;
	logic          out_ready = 0;
	e2r_pkg::rsp_t out_data;

	matrix_scoreboard sb = new();
	bit   sending_done = 0;
	bit   hold_active = 0;
	int   idle_cycles = 0;

	euler_to_rotation_matrix uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// idle with a chance of roughly 29 in 100, except in the quiet window
	function automatic bit idle_now(int n);
		if (n >= 100 && n < 250) return 0;
		return $urandom_range(99) < 29;
	endfunction

	// offer one request and wait for it to be taken
	task automatic send_request(logic [15:0] r, logic [15:0] p, logic [15:0] y, int n);
		while (idle_now(n)) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_data  <= '{roll_angle: r, pitch_angle: p, yaw_angle: y};
		do @(posedge clk); while (!in_ready);
		sb.note_request(in_data);
	endtask

	function automatic logic [15:0] rand_angle();
		case ($urandom_range(5))
			0: return 16'h8000 ^ 16'($urandom_range(3));
			1: return 16'(($urandom_range(7) << 13) + $urandom_range(8) - 4);
			default: return 16'($urandom);
		endcase
	endfunction

	// stimulus
	initial begin
		logic [15:0] d[12];
		int n;
		d = '{16'h0000, 16'h8000, 16'h7FFF, 16'h4000, 16'hC000, 16'h2000,
			16'hE000, 16'h6000, 16'hA000, 16'h0001, 16'hFFFF, 16'h1FFF};
		n = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		for (int i = 0; i < 12; i++) begin
			send_request(d[i], d[(i + 4) % 12], d[(i + 8) % 12], n);
			n++;
		end
		send_request(16'h8000, 16'h8000, 16'h8000, n);
		n++;
		send_request(16'h7FFF, 16'h7FFF, 16'h7FFF, n);
		n++;
		send_request(16'hFFFF, 16'h8001, 16'h0001, n);
		n++;
		repeat (N_RANDOM) begin
			send_request(rand_angle(), rand_angle(), rand_angle(), n);
			n++;
		end
		in_valid <= 0;
		sending_done = 1;
	end

	// receiver, with one long hold-off early on
	initial begin
		int k;
		k = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_result(out_data);
			k++;
			if (k == 300)
				hold_active = 1;
			if (k == 400)
				hold_active = 0;
			out_ready <= !hold_active && !(k > 600 && k < 800 ? 0 : $urandom_range(99) < 29);
		end
	end

	// watchdog and end of run
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG) begin
				$display("CHECKS FAILED");
				$finish;
			end
			if (sending_done && sb.pending.size() == 0) begin
				repeat (e2r_pkg::NSTG + 20) @(posedge clk);
				if (sb.errors == 0 && sb.pending.size() == 0)
					$display("ALL CHECKS PASSED");
				else
					$display("CHECKS FAILED");
				$finish;
			end
		end
	end

endmodule

@@ filelist.f @@
sv/e2r_pkg.sv
sv/e2r_cordic.sv
sv/e2r_merge.sv
sv/euler_to_rotation_matrix.sv
test/tb_euler_to_rotation_matrix.sv
